// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the scanner modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is high.
`define ASSERT_DIS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/dts_pkg.sv =====
`timescale 1ns / 1ps
package dts_pkg;

   // Scanner states; a token state carries its kind code, save ST_AMP and ST_BAR.
   typedef enum logic [4:0] {
      ST_IDLE   = 5'd0,
      ST_INT    = 5'd2,
      ST_REAL   = 5'd3,
      ST_ADDOP  = 5'd4,
      ST_MULOP  = 5'd5,
      ST_ID     = 5'd6,
      ST_RELOP  = 5'd7,
      ST_ASSIGN = 5'd8,
      ST_LPAREN = 5'd9,
      ST_RPAREN = 5'd10,
      ST_SEMI   = 5'd11,
      ST_LBRACK = 5'd12,
      ST_RBRACK = 5'd13,
      ST_COMMA  = 5'd14,
      ST_AND    = 5'd15,
      ST_OR     = 5'd16,
      ST_AMP    = 5'd17,
      ST_BAR    = 5'd18
   } scan_state_type;

   localparam logic [4:0] KIND_ERROR   = 5'd0;
   localparam logic [4:0] KIND_EOF     = 5'd1;
   localparam int         KIND_KW_BASE = 17;

   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CHAR_HASH   = "#";
   localparam logic [7:0] CHAR_DOT    = ".";
   localparam logic [7:0] CHAR_AMP    = "&";
   localparam logic [7:0] CHAR_BAR    = "|";
   localparam logic [7:0] CHAR_PLUS   = "+";
   localparam logic [7:0] CHAR_MINUS  = "-";
   localparam logic [7:0] CHAR_STAR   = "*";
   localparam logic [7:0] CHAR_SLASH  = "/";
   localparam logic [7:0] CHAR_LT     = "<";
   localparam logic [7:0] CHAR_GT     = ">";
   localparam logic [7:0] CHAR_EQ     = "=";
   localparam logic [7:0] CHAR_LPAREN = "(";
   localparam logic [7:0] CHAR_RPAREN = ")";
   localparam logic [7:0] CHAR_SEMI   = ";";
   localparam logic [7:0] CHAR_LBRACK = "[";
   localparam logic [7:0] CHAR_RBRACK = "]";
   localparam logic [7:0] CHAR_COMMA  = ",";
   localparam logic [7:0] CHAR_SPACE  = " ";
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_NL     = 8'h0A;

   // Keyword spellings, first letter in the top byte, padded with spaces.
   localparam logic [39:0] KW_TEXT [16] = '{
      "int  ", "float", "while", "if   ", "then ", "else ", "void ", "begin",
      "end  ", "     ", "     ", "     ", "     ", "     ", "     ", "     "
   };
   localparam logic [2:0] KW_LEN [16] = '{
      3'd3, 3'd5, 3'd5, 3'd2, 3'd4, 3'd4, 3'd4, 3'd5,
      3'd3, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
   };

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [15:0] line_number;
      logic [7:0]  lexeme_length;
      logic        last_result;
   } result_type;

   // Tokens produced by one input byte, oldest in first.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } step_out_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

   function automatic logic [7:0] kw_char(input logic [3:0] idx, input logic [2:0] pos);
      logic [7:0] ch;
      case (pos)
         3'd0: ch = KW_TEXT[idx][39:32];
         3'd1: ch = KW_TEXT[idx][31:24];
         3'd2: ch = KW_TEXT[idx][23:16];
         3'd3: ch = KW_TEXT[idx][15:8];
         3'd4: ch = KW_TEXT[idx][7:0];
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic result_type make_result(input logic [4:0] kind,
                                              input logic [15:0] line,
                                              input logic [7:0] len);
      result_type r;
      r.token_kind    = kind;
      r.line_number   = line;
      r.lexeme_length = len;
      r.last_result   = 1'b0;
      return r;
   endfunction

   // Transition of the automaton; ST_IDLE means the byte does not continue the token.
   function automatic scan_state_type next_scan(input scan_state_type s,
                                                input logic [7:0] c);
      scan_state_type n;
      n = ST_IDLE;
      case (s)
         ST_IDLE: begin
            if (is_digit(c)) n = ST_INT;
            else if (is_letter(c)) n = ST_ID;
            else begin
               case (c)
                  CHAR_PLUS, CHAR_MINUS: n = ST_ADDOP;
                  CHAR_STAR, CHAR_SLASH: n = ST_MULOP;
                  CHAR_LT, CHAR_GT:      n = ST_RELOP;
                  CHAR_EQ:               n = ST_ASSIGN;
                  CHAR_LPAREN:           n = ST_LPAREN;
                  CHAR_RPAREN:           n = ST_RPAREN;
                  CHAR_SEMI:             n = ST_SEMI;
                  CHAR_LBRACK:           n = ST_LBRACK;
                  CHAR_RBRACK:           n = ST_RBRACK;
                  CHAR_COMMA:            n = ST_COMMA;
                  CHAR_AMP:              n = ST_AMP;
                  CHAR_BAR:              n = ST_BAR;
                  default:               n = ST_IDLE;
               endcase
            end
         end
         ST_INT: begin
            if (is_digit(c)) n = ST_INT;
            else if (c == CHAR_DOT) n = ST_REAL;
         end
         ST_REAL: begin
            if (is_digit(c)) n = ST_REAL;
         end
         ST_ID: begin
            if (is_letter(c) || is_digit(c)) n = ST_ID;
         end
         ST_RELOP, ST_ASSIGN: begin
            if (c == CHAR_EQ) n = ST_RELOP;
         end
         ST_AMP: begin
            if (c == CHAR_AMP) n = ST_AND;
         end
         ST_BAR: begin
            if (c == CHAR_BAR) n = ST_OR;
         end
         default: n = ST_IDLE;
      endcase
      return n;
   endfunction

endpackage

// ===== hdl/dts_scan_core.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dts_scan_core #(
   parameter int KEYWORD_COUNT = 9,
   parameter int LENGTH_BITS   = 8,
   parameter int LINE_BITS     = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           char_byte,
   input  logic                 end_of_input,
   output dts_pkg::step_out_type step_out
);
   import dts_pkg::*;

   scan_state_type           state_ff, state_in;
   logic                     in_comment_ff, in_comment_in;
   logic [LINE_BITS-1:0]     line_ff, line_in;
   logic [LENGTH_BITS-1:0]   length_ff, length_in;
   logic [KEYWORD_COUNT-1:0] alive_ff, alive_in;

   scan_state_type           cont_state;
   scan_state_type           start_state;
   logic [KEYWORD_COUNT-1:0] keep_cont;
   logic [KEYWORD_COUNT-1:0] keep_start;
   logic [15:0]              line_sat;
   logic [7:0]               length_sat;
   logic [LINE_BITS-1:0]     line_next;
   logic [4:0]               finish_kind;
   logic                     is_newline;

   assign cont_state  = next_scan(state_ff, char_byte);
   assign start_state = next_scan(ST_IDLE, char_byte);
   assign is_newline  = (char_byte == CHAR_NL);
   assign line_next   = (line_ff != '1) ? line_ff + LINE_BITS'(1) : line_ff;

   assign line_sat   = ((LINE_BITS > 16) && ((line_ff >> 16) != '0)) ? 16'hFFFF
                                                                   : 16'(line_ff);
   assign length_sat = ((LENGTH_BITS > 8) && ((length_ff >> 8) != '0)) ? 8'hFF
                                                                      : 8'(length_ff);

   // Narrow the keyword candidates by the byte at the current position.
   always_comb begin
      for (int i = 0; i < KEYWORD_COUNT; i++) begin
         keep_cont[i]  = (length_ff < LENGTH_BITS'(KW_LEN[i])) &&
                         (kw_char(4'(i), length_ff[2:0]) == char_byte);
         keep_start[i] = (KW_LEN[i] != 3'd0) && (kw_char(4'(i), 3'd0) == char_byte);
      end
   end

   always_comb begin
      finish_kind = state_ff;
      if ((state_ff == ST_AMP) || (state_ff == ST_BAR)) finish_kind = KIND_ERROR;
      if (state_ff == ST_ID) begin
         for (int i = 0; i < KEYWORD_COUNT; i++) begin
            if (alive_ff[i] && (length_ff == LENGTH_BITS'(KW_LEN[i])))
               finish_kind = 5'(KIND_KW_BASE + i);
         end
      end
   end

   always_comb begin
      logic run_idle;
      state_in      = state_ff;
      in_comment_in = in_comment_ff;
      line_in       = line_ff;
      length_in     = length_ff;
      alive_in      = alive_ff;
      step_out      = '0;
      run_idle      = 1'b0;
      if (accept) begin
         if (end_of_input) begin
            if (state_ff != ST_IDLE) begin
               step_out.count  = 2'd2;
               step_out.first  = make_result(finish_kind, line_sat, length_sat);
               step_out.second = make_result(KIND_EOF, line_sat, 8'd0);
            end else begin
               step_out.count = 2'd1;
               step_out.first = make_result(KIND_EOF, line_sat, 8'd0);
            end
            state_in      = ST_IDLE;
            length_in     = '0;
            alive_in      = '1;
            in_comment_in = 1'b0;
         end else begin
            run_idle = 1'b1;
            if (state_ff != ST_IDLE) begin
               if (cont_state != ST_IDLE) begin
                  // extend the pending token
                  state_in  = cont_state;
                  alive_in  = alive_ff & keep_cont;
                  length_in = (length_ff != '1) ? length_ff + LENGTH_BITS'(1) : length_ff;
                  run_idle  = 1'b0;
               end else begin
                  // close the token, then rescan this byte as a fresh start
                  step_out.count = 2'd1;
                  step_out.first = make_result(finish_kind, line_sat, length_sat);
                  state_in       = ST_IDLE;
                  length_in      = '0;
                  alive_in       = '1;
               end
            end
            if (run_idle) begin
               if (in_comment_ff) begin
                  if (is_newline) begin
                     line_in       = line_next;
                     in_comment_in = 1'b0;
                  end
               end else if (char_byte == CHAR_HASH) begin
                  in_comment_in = 1'b1;
               end else if (is_blank(char_byte)) begin
                  if (is_newline) line_in = line_next;
               end else if (start_state == ST_IDLE) begin
                  // bad byte: consume it as a one-byte error token
                  if (step_out.count == 2'd1) begin
                     step_out.count  = 2'd2;
                     step_out.second = make_result(KIND_ERROR, line_sat, 8'd1);
                  end else begin
                     step_out.count = 2'd1;
                     step_out.first = make_result(KIND_ERROR, line_sat, 8'd1);
                  end
               end else begin
                  state_in  = start_state;
                  length_in = LENGTH_BITS'(1);
                  alive_in  = keep_start;
               end
            end
         end
         if (step_out.count == 2'd1) step_out.first.last_result = 1'b1;
         if (step_out.count == 2'd2) step_out.second.last_result = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         in_comment_ff <= 1'b0;
         line_ff       <= LINE_BITS'(1);
         length_ff     <= '0;
         alive_ff      <= '1;
      end else begin
         state_ff      <= state_in;
         in_comment_ff <= in_comment_in;
         line_ff       <= line_in;
         length_ff     <= length_in;
         alive_ff      <= alive_in;
      end
   end

   `ASSERT_DIS(a_eoi_clears, clock, reset, (accept && end_of_input) |=> ((state_ff == ST_IDLE) && !in_comment_ff && (length_ff == '0) && (alive_ff == '1)), "end of input left token state behind")
   `ASSERT_DIS(a_comment_idle, clock, reset, in_comment_ff |-> (state_ff == ST_IDLE), "token pending inside a comment")
   `ASSERT_DIS(a_line_nonzero, clock, reset, (line_ff != '0) && ((line_ff >= $past(line_ff)) || $past(reset)), "line counter moved backward")

endmodule

// ===== hdl/dts_result_queue.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dts_result_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  dts_pkg::step_out_type push,
   output logic                  in_ready,
   output logic                  out_valid,
   input  logic                  out_ready,
   output dts_pkg::result_type   out_word
);
   import dts_pkg::*;

   localparam int CW = PTR_BITS + 1;

   result_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != '0);
   assign out_word  = entry_ff[rd_ptr_ff];
   // room for the two words one input byte can produce
   assign in_ready  = (count_ff <= CW'(QUEUE_DEPTH - 2));

   assign wr_ptr_in = wr_ptr_ff + PTR_BITS'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PTR_BITS'(pop);
   assign count_in  = count_ff + CW'(push.count) - CW'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) entry_ff[wr_ptr_ff] <= push.first;
      if (push.count == 2'd2) entry_ff[wr_ptr_ff + PTR_BITS'(1)] <= push.second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `ASSERT_ALWAYS(a_no_overflow, clock, reset || (count_ff <= CW'(QUEUE_DEPTH)), "result queue overflow")
   `ASSERT_DIS(a_push_two, clock, reset, ((push.count == 2'd2) && !pop) |=> (count_ff == $past(count_ff) + CW'(2)), "double push lost a word")
   `ASSERT_DIS(a_ptr_gap, clock, reset, (PTR_BITS'(wr_ptr_ff - rd_ptr_ff) == PTR_BITS'(count_ff)), "queue pointers disagree with fill count")

endmodule

// ===== hdl/dfa_token_scanner.sv =====
`timescale 1ns / 1ps
// A token word is written to the result queue as the byte that ends it is accepted.
// Throughput: one byte per cycle while req_tready is high; the four-word result queue
// drains one token per cycle while rsp is ready. req stalls once the queue holds three or
// more words, even with rsp always ready, and resumes when it is back down to two.
// Reset: synchronous, active high; scanner idle, line counter at one, queue empty.
module dfa_token_scanner #(
   parameter int KEYWORD_COUNT = 9,
   parameter int LENGTH_BITS   = 8,
   parameter int LINE_BITS     = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_byte
   input  logic        req_tlast,   // end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [4:0] token_kind, [20:5] line_number,
                                    // [28:21] lexeme_length, [31:29] zero
   output logic        rsp_tlast    // last_result
);
   import dts_pkg::*;

   step_out_type step_out;
   result_type   head;
   logic         accept;

   assign accept = req_tvalid && req_tready;

   dts_scan_core #(
      .KEYWORD_COUNT (KEYWORD_COUNT),
      .LENGTH_BITS   (LENGTH_BITS),
      .LINE_BITS     (LINE_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .char_byte    (req_tdata),
      .end_of_input (req_tlast),
      .step_out     (step_out)
   );

   dts_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (step_out),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (head)
   );

   assign rsp_tdata = {3'b000, head.lexeme_length, head.line_number, head.token_kind};
   assign rsp_tlast = head.last_result;

endmodule
